FILE: rtl/y86_pkg.sv
`default_nettype none

package y86_pkg;

  localparam int unsigned NumRegs = 15;

  localparam logic [3:0] RegRsp  = 4'd4;
  localparam logic [3:0] RegNone = 4'hF;

  localparam logic [1:0] StAok = 2'd0;
  localparam logic [1:0] StHlt = 2'd1;
  localparam logic [1:0] StAdr = 2'd2;
  localparam logic [1:0] StIns = 2'd3;

  localparam logic [1:0] CmdLoad   = 2'd0;
  localparam logic [1:0] CmdExec   = 2'd1;
  localparam logic [1:0] CmdRdReg  = 2'd2;
  localparam logic [1:0] CmdRdWord = 2'd3;

  localparam logic [3:0] IHalt  = 4'h0;
  localparam logic [3:0] INop   = 4'h1;
  localparam logic [3:0] ICmov  = 4'h2;
  localparam logic [3:0] IIrmov = 4'h3;
  localparam logic [3:0] IRmmov = 4'h4;
  localparam logic [3:0] IMrmov = 4'h5;
  localparam logic [3:0] IOp    = 4'h6;
  localparam logic [3:0] IJxx   = 4'h7;
  localparam logic [3:0] ICall  = 4'h8;
  localparam logic [3:0] IRet   = 4'h9;
  localparam logic [3:0] IPush  = 4'hA;
  localparam logic [3:0] IPop   = 4'hB;

  localparam logic [3:0] FnAdd = 4'd0;
  localparam logic [3:0] FnSub = 4'd1;
  localparam logic [3:0] FnAnd = 4'd2;
  localparam logic [3:0] FnXor = 4'd3;

  typedef enum logic [2:0] {
    MA_CLR,
    MA_LOAD,
    MA_PC,
    MA_PC1,
    MA_WORD
  } ma_sel_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_DATA,
    WD_STORE
  } wd_sel_e;

  typedef enum logic [1:0] {
    RS_RIDX,
    RS_A,
    RS_B,
    RS_SP
  } rs_sel_e;

  typedef struct packed {
    logic       in_load;
    ma_sel_e    ma_sel;
    logic       mem_we;
    wd_sel_e    wd_sel;
    logic       clr_inc;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       word_shift;
    logic       st_load;
    logic       st_shift;
    logic       decode;
    logic       regs_cap;
    logic       valc_cap;
    rs_sel_e    rs_sel;
    logic       vala_cap;
    logic       valb_cap;
    logic       rv_from_rf;
    logic       rv_from_word;
    logic       exec;
    logic       wa_from_in;
    logic       rf_we;
    logic       wb_pop;
    logic       pc_upd;
    logic       stat_we;
    logic [1:0] stat_val;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       ld_ok;
    logic       run_ok;
    logic       pc_ok;
    logic       pc1_ok;
    logic       wa_ok;
    logic [3:0] f_icode;
    logic [3:0] icode;
    logic       cnt_rd_last;
    logic       cnt_wr_last;
    logic       clr_last;
  } dp_sts_t;

  function automatic logic fetch_regs(input logic [3:0] ic);
    return ic == ICmov || ic == IIrmov || ic == IRmmov || ic == IMrmov ||
           ic == IOp || ic == IPush || ic == IPop;
  endfunction

  function automatic logic fetch_const(input logic [3:0] ic);
    return ic == IIrmov || ic == IRmmov || ic == IMrmov || ic == IJxx || ic == ICall;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/y86_dp.sv
`default_nettype none

module y86_dp #(
  parameter int unsigned MEM_BYTES = 8192
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire y86_pkg::dp_cmd_t cmd_i,
  output y86_pkg::dp_sts_t      sts_o,
  input  wire logic [1:0]       command_i,
  input  wire logic [12:0]      address_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [3:0]       reg_index_i,
  output logic [1:0]            status_o,
  output logic [63:0]           pc_o,
  output logic                  zf_o,
  output logic                  sf_o,
  output logic                  of_o,
  output logic [63:0]           read_value_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [63:0] MemLim  = 64'(MEM_BYTES);
  localparam logic [63:0] WordMax = 64'(MEM_BYTES - 8);
  localparam logic [AW-1:0] ClrMax = AW'(MEM_BYTES - 1);

  logic [1:0]  cmd_q;
  logic [12:0] addr_q;
  logic [7:0]  data_q;
  logic [3:0]  ridx_q;

  logic [63:0] pc_q;
  logic [1:0]  stat_q;
  logic        zf_q, sf_q, of_q;
  logic [AW-1:0] clr_q;
  logic [3:0]  cnt_q;

  logic [3:0]  icode_q, ifun_q, ra_q, rb_q;
  logic [63:0] valp_q, valc_q, vala_q, valb_q, vale_q;
  logic [63:0] wa_q, word_q, st_q, rv_q;
  logic        cnd_q;

  logic [7:0]  mem_q [MEM_BYTES];
  logic [7:0]  mem_rd_q;
  logic [AW-1:0] ma;
  logic [7:0]  wd;

  logic [63:0] rf_q [y86_pkg::NumRegs];
  logic [y86_pkg::NumRegs-1:0] rfv_q;
  logic [63:0] rf_rd_q;
  logic [3:0]  rf_ra;
  logic [3:0]  wdst;
  logic [63:0] wval;
  logic [63:0] pc_nx;

  logic [63:0] word_nx;
  logic [3:0]  f_icode;
  logic [3:0]  flen;

  logic        lt, eq, cnd;
  logic [63:0] opy, sum, alu_r, vale;
  logic        cin, ovf;

  assign f_icode = mem_rd_q[7:4];
  assign word_nx = {mem_rd_q, word_q[63:8]};
  assign flen    = 4'd1 + {3'd0, y86_pkg::fetch_regs(f_icode)} +
                   {y86_pkg::fetch_const(f_icode), 3'b000};

  always_comb begin
    case (cmd_i.ma_sel)
      y86_pkg::MA_CLR:  ma = clr_q;
      y86_pkg::MA_LOAD: ma = AW'(addr_q);
      y86_pkg::MA_PC:   ma = pc_q[AW-1:0];
      y86_pkg::MA_PC1:  ma = pc_q[AW-1:0] + AW'(1);
      y86_pkg::MA_WORD: ma = wa_q[AW-1:0] + AW'(cnt_q);
      default:          ma = clr_q;
    endcase
    case (cmd_i.wd_sel)
      y86_pkg::WD_DATA:  wd = data_q;
      y86_pkg::WD_STORE: wd = st_q[7:0];
      default:           wd = 8'd0;
    endcase
    case (cmd_i.rs_sel)
      y86_pkg::RS_A:  rf_ra = ra_q;
      y86_pkg::RS_B:  rf_ra = rb_q;
      y86_pkg::RS_SP: rf_ra = y86_pkg::RegRsp;
      default:        rf_ra = ridx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[ma] <= wd;
    end
    mem_rd_q <= mem_q[ma];
  end

  always_comb begin
    lt = sf_q ^ of_q;
    eq = zf_q;
    case (ifun_q)
      4'd0:    cnd = 1'b1;
      4'd1:    cnd = lt | eq;
      4'd2:    cnd = lt;
      4'd3:    cnd = eq;
      4'd4:    cnd = ~eq;
      4'd5:    cnd = ~lt;
      4'd6:    cnd = ~(lt | eq);
      default: cnd = 1'b0;
    endcase
    opy = '0;
    cin = 1'b0;
    case (icode_q)
      y86_pkg::IOp: begin
        if (ifun_q == y86_pkg::FnSub) begin
          opy = ~vala_q;
          cin = 1'b1;
        end else begin
          opy = vala_q;
        end
      end
      y86_pkg::IRmmov, y86_pkg::IMrmov: opy = valc_q;
      y86_pkg::ICall, y86_pkg::IPush:   opy = ~64'd7;
      default:                          opy = '0;
    endcase
    sum = valb_q + opy + 64'(cin);
    case (ifun_q)
      y86_pkg::FnAdd, y86_pkg::FnSub: alu_r = sum;
      y86_pkg::FnAnd:                 alu_r = valb_q & vala_q;
      y86_pkg::FnXor:                 alu_r = valb_q ^ vala_q;
      default:                        alu_r = '0;
    endcase
    case (ifun_q)
      y86_pkg::FnAdd: ovf = (vala_q[63] == valb_q[63]) && (sum[63] != valb_q[63]);
      y86_pkg::FnSub: ovf = (vala_q[63] != valb_q[63]) && (sum[63] != valb_q[63]);
      default:        ovf = 1'b0;
    endcase
    vale = (icode_q == y86_pkg::IOp) ? alu_r : sum;
  end

  always_comb begin
    wdst = y86_pkg::RegNone;
    wval = '0;
    if (cmd_i.wb_pop) begin
      wdst = ra_q;
      wval = word_q;
    end else begin
      case (icode_q)
        y86_pkg::ICmov: begin
          wdst = cnd_q ? rb_q : y86_pkg::RegNone;
          wval = vala_q;
        end
        y86_pkg::IIrmov: begin
          wdst = rb_q;
          wval = valc_q;
        end
        y86_pkg::IMrmov: begin
          wdst = ra_q;
          wval = word_q;
        end
        y86_pkg::IOp: begin
          wdst = rb_q;
          wval = vale_q;
        end
        y86_pkg::ICall, y86_pkg::IPush: begin
          wdst = y86_pkg::RegRsp;
          wval = vale_q;
        end
        y86_pkg::IRet, y86_pkg::IPop: begin
          wdst = y86_pkg::RegRsp;
          wval = vale_q + 64'd8;
        end
        default: begin
          wdst = y86_pkg::RegNone;
          wval = '0;
        end
      endcase
    end
    case (icode_q)
      y86_pkg::IJxx:  pc_nx = cnd_q ? valc_q : valp_q;
      y86_pkg::ICall: pc_nx = valc_q;
      y86_pkg::IRet:  pc_nx = word_q;
      default:        pc_nx = valp_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rf_we && wdst != y86_pkg::RegNone) begin
      rf_q[wdst] <= wval;
    end
    rf_rd_q <= (rf_ra != y86_pkg::RegNone && rfv_q[rf_ra]) ? rf_q[rf_ra] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rfv_q  <= '0;
      pc_q   <= '0;
      stat_q <= y86_pkg::StAok;
      zf_q   <= 1'b1;
      sf_q   <= 1'b0;
      of_q   <= 1'b0;
      clr_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.rf_we && wdst != y86_pkg::RegNone) begin
        rfv_q[wdst] <= 1'b1;
      end
      if (cmd_i.pc_upd) begin
        pc_q <= pc_nx;
      end
      if (cmd_i.stat_we) begin
        stat_q <= cmd_i.stat_val;
      end
      if (cmd_i.exec && icode_q == y86_pkg::IOp) begin
        zf_q <= (alu_r == 64'd0);
        sf_q <= alu_r[63];
        of_q <= ovf;
      end
      if (cmd_i.clr_inc) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cmd_q  <= command_i;
      addr_q <= address_i;
      data_q <= data_byte_i;
      ridx_q <= reg_index_i;
    end
    if (cmd_i.decode) begin
      icode_q <= mem_rd_q[7:4];
      ifun_q  <= mem_rd_q[3:0];
      ra_q    <= y86_pkg::RegNone;
      rb_q    <= y86_pkg::RegNone;
      valp_q  <= pc_q + 64'(flen);
    end else if (cmd_i.regs_cap) begin
      ra_q <= mem_rd_q[7:4];
      rb_q <= mem_rd_q[3:0];
    end
    if (cmd_i.decode) begin
      wa_q <= pc_q + 64'd1;
    end else if (cmd_i.regs_cap) begin
      wa_q <= pc_q + 64'd2;
    end else if (cmd_i.wa_from_in) begin
      wa_q <= 64'(addr_q);
    end else if (cmd_i.exec) begin
      wa_q <= sum;
    end
    if (cmd_i.word_shift && cnt_q != 4'd0) begin
      word_q <= word_nx;
    end
    if (cmd_i.valc_cap) begin
      valc_q <= word_nx;
    end
    if (cmd_i.vala_cap) begin
      vala_q <= rf_rd_q;
    end
    if (cmd_i.valb_cap) begin
      valb_q <= rf_rd_q;
    end
    if (cmd_i.exec) begin
      vale_q <= vale;
      cnd_q  <= cnd;
    end
    if (cmd_i.st_load) begin
      st_q <= (icode_q == y86_pkg::ICall) ? valp_q : vala_q;
    end else if (cmd_i.st_shift) begin
      st_q <= {8'd0, st_q[63:8]};
    end
    if (cmd_i.in_load) begin
      rv_q <= '0;
    end else if (cmd_i.rv_from_rf) begin
      rv_q <= rf_rd_q;
    end else if (cmd_i.rv_from_word) begin
      rv_q <= word_nx;
    end
  end

  always_comb begin
    sts_o.in_cmd      = cmd_q;
    sts_o.ld_ok       = 64'(addr_q) < MemLim;
    sts_o.run_ok      = stat_q == y86_pkg::StAok;
    sts_o.pc_ok       = pc_q < MemLim;
    sts_o.pc1_ok      = (pc_q + 64'd1) < MemLim;
    sts_o.wa_ok       = wa_q <= WordMax;
    sts_o.f_icode     = f_icode;
    sts_o.icode       = icode_q;
    sts_o.cnt_rd_last = cnt_q == 4'd8;
    sts_o.cnt_wr_last = cnt_q == 4'd7;
    sts_o.clr_last    = clr_q == ClrMax;
  end

  assign status_o     = stat_q;
  assign pc_o         = pc_q;
  assign zf_o         = zf_q;
  assign sf_o         = sf_q;
  assign of_o         = of_q;
  assign read_value_o = rv_q;

`ifndef ASSERT_OFF
  a_stat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_q != y86_pkg::StAok) |=> (stat_q == $past(stat_q)))
    else $error("status left a stop state");
  a_word_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mem_we && cmd_i.ma_sel == y86_pkg::MA_WORD) |-> (wa_q <= WordMax))
    else $error("word store outside memory");
  a_valc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valc_cap || cmd_i.rv_from_word) |-> (cnt_q == 4'd8))
    else $error("word taken before all bytes arrived");
`endif

endmodule

`default_nettype wire

FILE: rtl/y86_ctrl.sv
`default_nettype none

module y86_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_free_i,
  output logic                  out_load_o,
  input  wire y86_pkg::dp_sts_t sts_i,
  output y86_pkg::dp_cmd_t      cmd_o
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_RREG = 5'd3;
  localparam logic [4:0] S_C3   = 5'd4;
  localparam logic [4:0] S_RDC  = 5'd5;
  localparam logic [4:0] S_F0   = 5'd6;
  localparam logic [4:0] S_F1   = 5'd7;
  localparam logic [4:0] S_F2   = 5'd8;
  localparam logic [4:0] S_F3   = 5'd9;
  localparam logic [4:0] S_RDV  = 5'd10;
  localparam logic [4:0] S_REGA = 5'd11;
  localparam logic [4:0] S_REGB = 5'd12;
  localparam logic [4:0] S_REGC = 5'd13;
  localparam logic [4:0] S_EXEC = 5'd14;
  localparam logic [4:0] S_MCHK = 5'd15;
  localparam logic [4:0] S_WR   = 5'd16;
  localparam logic [4:0] S_RDD  = 5'd17;
  localparam logic [4:0] S_WB   = 5'd18;
  localparam logic [4:0] S_WB2  = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  logic [4:0] state_q, state_d;
  logic       mem_wr, mem_rd, stk_op;

  assign mem_wr = sts_i.icode == y86_pkg::IRmmov || sts_i.icode == y86_pkg::ICall ||
                  sts_i.icode == y86_pkg::IPush;
  assign mem_rd = sts_i.icode == y86_pkg::IMrmov || sts_i.icode == y86_pkg::IRet ||
                  sts_i.icode == y86_pkg::IPop;
  assign stk_op = sts_i.icode == y86_pkg::ICall || sts_i.icode == y86_pkg::IRet ||
                  sts_i.icode == y86_pkg::IPush || sts_i.icode == y86_pkg::IPop;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.ma_sel  = y86_pkg::MA_CLR;
        cmd_o.wd_sel  = y86_pkg::WD_ZERO;
        cmd_o.mem_we  = 1'b1;
        cmd_o.clr_inc = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.in_cmd)
          y86_pkg::CmdLoad: begin
            cmd_o.ma_sel = y86_pkg::MA_LOAD;
            cmd_o.wd_sel = y86_pkg::WD_DATA;
            cmd_o.mem_we = sts_i.ld_ok;
            state_d = S_DONE;
          end
          y86_pkg::CmdExec: state_d = sts_i.run_ok ? S_F0 : S_DONE;
          y86_pkg::CmdRdReg: begin
            cmd_o.rs_sel = y86_pkg::RS_RIDX;
            state_d = S_RREG;
          end
          default: begin
            cmd_o.wa_from_in = 1'b1;
            state_d = S_C3;
          end
        endcase
      end
      S_RREG: begin
        cmd_o.rv_from_rf = 1'b1;
        state_d = S_DONE;
      end
      S_C3: begin
        if (sts_i.wa_ok) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_RDC;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RDC: begin
        cmd_o.ma_sel     = y86_pkg::MA_WORD;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.word_shift = 1'b1;
        if (sts_i.cnt_rd_last) begin
          cmd_o.rv_from_word = 1'b1;
          state_d = S_DONE;
        end
      end
      S_F0: begin
        cmd_o.ma_sel = y86_pkg::MA_PC;
        if (sts_i.pc_ok) begin
          state_d = S_F1;
        end else begin
          cmd_o.stat_we  = 1'b1;
          cmd_o.stat_val = y86_pkg::StAdr;
          state_d = S_DONE;
        end
      end
      S_F1: begin
        cmd_o.decode = 1'b1;
        cmd_o.ma_sel = y86_pkg::MA_PC1;
        if (sts_i.f_icode > y86_pkg::IPop) begin
          cmd_o.stat_we  = 1'b1;
          cmd_o.stat_val = y86_pkg::StIns;
          state_d = S_DONE;
        end else if (sts_i.f_icode == y86_pkg::IHalt) begin
          cmd_o.stat_we  = 1'b1;
          cmd_o.stat_val = y86_pkg::StHlt;
          state_d = S_DONE;
        end else if (y86_pkg::fetch_regs(sts_i.f_icode)) begin
          if (sts_i.pc1_ok) begin
            state_d = S_F2;
          end else begin
            cmd_o.stat_we  = 1'b1;
            cmd_o.stat_val = y86_pkg::StAdr;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_F3;
        end
      end
      S_F2: begin
        cmd_o.regs_cap = 1'b1;
        state_d = S_F3;
      end
      S_F3: begin
        if (!y86_pkg::fetch_const(sts_i.icode)) begin
          state_d = S_REGA;
        end else if (sts_i.wa_ok) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_RDV;
        end else begin
          cmd_o.stat_we  = 1'b1;
          cmd_o.stat_val = y86_pkg::StAdr;
          state_d = S_DONE;
        end
      end
      S_RDV: begin
        cmd_o.ma_sel     = y86_pkg::MA_WORD;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.word_shift = 1'b1;
        if (sts_i.cnt_rd_last) begin
          cmd_o.valc_cap = 1'b1;
          state_d = S_REGA;
        end
      end
      S_REGA: begin
        cmd_o.rs_sel = y86_pkg::RS_A;
        state_d = S_REGB;
      end
      S_REGB: begin
        cmd_o.rs_sel   = stk_op ? y86_pkg::RS_SP : y86_pkg::RS_B;
        cmd_o.vala_cap = 1'b1;
        state_d = S_REGC;
      end
      S_REGC: begin
        cmd_o.valb_cap = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_MCHK;
      end
      S_MCHK: begin
        if ((mem_wr || mem_rd) && !sts_i.wa_ok) begin
          cmd_o.stat_we  = 1'b1;
          cmd_o.stat_val = y86_pkg::StAdr;
          state_d = S_DONE;
        end else if (mem_wr) begin
          cmd_o.st_load = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d = S_WR;
        end else if (mem_rd) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_RDD;
        end else begin
          state_d = S_WB;
        end
      end
      S_WR: begin
        cmd_o.ma_sel   = y86_pkg::MA_WORD;
        cmd_o.wd_sel   = y86_pkg::WD_STORE;
        cmd_o.mem_we   = 1'b1;
        cmd_o.st_shift = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (sts_i.cnt_wr_last) state_d = S_WB;
      end
      S_RDD: begin
        cmd_o.ma_sel     = y86_pkg::MA_WORD;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.word_shift = 1'b1;
        if (sts_i.cnt_rd_last) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.rf_we  = 1'b1;
        cmd_o.pc_upd = 1'b1;
        state_d = (sts_i.icode == y86_pkg::IPop) ? S_WB2 : S_DONE;
      end
      S_WB2: begin
        cmd_o.rf_we  = 1'b1;
        cmd_o.wb_pop = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("accepted item not dispatched");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> (state_q == S_IDLE))
    else $error("result issued without return to idle");
  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (!in_ready_o && !out_load_o))
    else $error("activity during memory clear");
`endif

endmodule

`default_nettype wire

FILE: rtl/y86_64_sequential_core_unit.sv
// Y86-64 sequential core, one command per item.
// Input channel: in_valid_i/in_ready_o with command_i, address_i, data_byte_i
// and reg_index_i. Output channel: out_valid_o/out_ready_i with status_o, pc_o,
// the three condition flags and read_value_o. Every item yields one result.
// An execute command fetches and runs one instruction, or does nothing when the
// status is already a stop state; mrmovq, the longest, fetches ten bytes, reads
// eight data bytes, does its register reads and takes an ALU step.
// The byte-wide single-port memory moves each fetched constant and each data
// word one byte a cycle, and the register file gives one read a cycle.
// Items are processed one at a time; the next item can be taken in the cycle in
// which the previous result first sits in the output register.
// After reset the memory is cleared one byte a cycle, and in_ready_o stays low
// until the clear is done. Registers read zero, pc is zero,
// status AOK, ZF set. If the receiver stalls, the result is held and the
// core stalls at the end of its next item until the output register frees.
`default_nettype none

module y86_64_sequential_core_unit #(
  parameter int unsigned MEM_BYTES = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [12:0] address_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [3:0]  reg_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [63:0]      pc_o,
  output logic             zero_flag_o,
  output logic             sign_flag_o,
  output logic             overflow_flag_o,
  output logic [63:0]      read_value_o
);

  y86_pkg::dp_cmd_t dp_cmd;
  y86_pkg::dp_sts_t dp_sts;
  logic             out_load;
  logic             out_free;
  logic             out_vld_q;
  logic [1:0]       dp_stat;
  logic [63:0]      dp_pc, dp_rv;
  logic             dp_zf, dp_sf, dp_of;

  assign out_free = !out_vld_q || out_ready_i;

  y86_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  y86_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .command_i    (command_i),
    .address_i    (address_i),
    .data_byte_i  (data_byte_i),
    .reg_index_i  (reg_index_i),
    .status_o     (dp_stat),
    .pc_o         (dp_pc),
    .zf_o         (dp_zf),
    .sf_o         (dp_sf),
    .of_o         (dp_of),
    .read_value_o (dp_rv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o        <= dp_stat;
      pc_o            <= dp_pc;
      zero_flag_o     <= dp_zf;
      sign_flag_o     <= dp_sf;
      overflow_flag_o <= dp_of;
      read_value_o    <= dp_rv;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire
